>>> sv/u8enc_pkg.sv
// Package with shared types, constants and the single-unit encoder function.
package u8enc_pkg;

    localparam int Q_DEPTH = 2;

    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [7:0]  RPL_BYTE    = 8'h3F;
    localparam logic [20:0] PLANE1_BASE = 21'h10000;
    localparam logic [15:0] MAX_1BYTE   = 16'h007F;
    localparam logic [15:0] MAX_2BYTE   = 16'h07FF;

    // Bytes of one unit's output, first byte in entry 0.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [3:0]      sub;
        logic [1:0]      last_idx;
    } t_job;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic            sub0;
        logic [1:0]      cnt;
        logic            hold;
    } t_enc;

    function automatic t_enc encode_fresh(input logic [15:0] cu, input logic last);
        t_enc e;
        e = '0;
        if (cu[15:10] == HI_SURR_TAG) begin
            if (last) begin
                e.bytes[0] = RPL_BYTE;
                e.sub0     = 1'b1;
                e.cnt      = 2'd1;
            end else begin
                e.hold = 1'b1;
            end
        end else if (cu[15:10] == LO_SURR_TAG) begin
            e.bytes[0] = RPL_BYTE;
            e.sub0     = 1'b1;
            e.cnt      = 2'd1;
        end else if (cu <= MAX_1BYTE) begin
            e.bytes[0] = cu[7:0];
            e.cnt      = 2'd1;
        end else if (cu <= MAX_2BYTE) begin
            e.bytes[0] = {3'b110, cu[10:6]};
            e.bytes[1] = {2'b10, cu[5:0]};
            e.cnt      = 2'd2;
        end else begin
            e.bytes[0] = {4'b1110, cu[15:12]};
            e.bytes[1] = {2'b10, cu[11:6]};
            e.bytes[2] = {2'b10, cu[5:0]};
            e.cnt      = 2'd3;
        end
        return e;
    endfunction

endpackage

>>> sv/utf16_to_utf8_encoder_top.sv
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue and byte serializer.
//
//  Channel   Dir  tdata              tuser        tlast
//  s_axis    in   [15:0] code_unit   -            last_unit
//  m_axis    out  [7:0]  out_byte    substituted  run_end
//
// A code unit is taken every cycle while the job queue has room; the serializer sends
// one byte per cycle while the output is not stalled; a unit gives 1 to 4 bytes, a held
// high surrogate none. Bytes pass the queue, job register and output register.
// Reset is synchronous and active low and clears the held surrogate, queue and output.
// Either side may stall; the queue lets the input run ahead of a stalled output.
module utf16_to_utf8_encoder_top #(
    parameter int QUEUE_DEPTH = u8enc_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] substituted
    output logic        m_axis_tlast
);
    import u8enc_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic qvalid;
    t_job in_job;
    t_job out_job;

    u8enc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_unit  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_job   (in_job)
    );

    u8enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (in_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_job   (out_job)
    );

    u8enc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .i_job    (out_job),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_sub    (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

endmodule

>>> sv/u8enc_front.sv
// Front end: accepts code units, tracks the held high surrogate and builds byte jobs.
module u8enc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [15:0]     i_unit,
    input  logic            i_last,
    input  logic            i_full,
    output logic            o_push,
    output u8enc_pkg::t_job o_job
);
    import u8enc_pkg::*;

    logic        r_pend;
    logic [9:0]  r_pay;
    logic        accept;
    logic        is_lo;
    logic        pair;
    logic [20:0] cp;
    logic [2:0]  cnt;
    t_enc        fresh;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign is_lo   = (i_unit[15:10] == LO_SURR_TAG);
    assign pair    = r_pend && is_lo;
    assign fresh   = encode_fresh(i_unit, i_last);
    assign cp      = PLANE1_BASE + {1'b0, r_pay, i_unit[9:0]};

    always_comb begin
        o_job = '0;
        cnt   = '0;
        if (pair) begin
            o_job.bytes[0] = {5'b11110, cp[20:18]};
            o_job.bytes[1] = {2'b10, cp[17:12]};
            o_job.bytes[2] = {2'b10, cp[11:6]};
            o_job.bytes[3] = {2'b10, cp[5:0]};
            cnt            = 3'd4;
        end else if (r_pend) begin
            o_job.bytes[0] = RPL_BYTE;
            o_job.bytes[1] = fresh.bytes[0];
            o_job.bytes[2] = fresh.bytes[1];
            o_job.bytes[3] = fresh.bytes[2];
            o_job.sub      = {2'b00, fresh.sub0, 1'b1};
            cnt            = {1'b0, fresh.cnt} + 3'd1;
        end else begin
            o_job.bytes[0] = fresh.bytes[0];
            o_job.bytes[1] = fresh.bytes[1];
            o_job.bytes[2] = fresh.bytes[2];
            o_job.sub      = {3'b000, fresh.sub0};
            cnt            = {1'b0, fresh.cnt};
        end
        o_job.last_idx = 2'(cnt - 3'd1);
    end

    assign o_push = accept && (cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (accept) begin
            r_pend <= fresh.hold && !pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pay <= i_unit[9:0];
        end
    end

endmodule

>>> sv/u8enc_queue.sv
// Short job queue between the front end and the byte serializer.
module u8enc_queue #(
    parameter int DEPTH = u8enc_pkg::Q_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8enc_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output u8enc_pkg::t_job o_job
);
    import u8enc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> sv/u8enc_back.sv
// Back end: serializes each job into one output byte per beat through an output register.
module u8enc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_qvalid,
    input  u8enc_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_sub,
    output logic            o_last
);
    import u8enc_pkg::*;

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_act;
    logic       r_ovld;
    logic [7:0] r_obyte;
    logic       r_osub;
    logic       r_olast;
    logic       slot_free;
    logic       load;
    logic       fin;

    assign slot_free = !r_ovld || i_ready;
    assign load      = r_act && slot_free;
    assign fin       = load && (r_idx == r_job.last_idx);
    assign o_pop     = i_qvalid && (!r_act || fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_ovld <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (slot_free) begin
                r_ovld <= load;
            end
            if (o_pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (fin) begin
                r_act <= 1'b0;
            end else if (load) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load) begin
            r_obyte <= r_job.bytes[r_idx];
            r_osub  <= r_job.sub[r_idx];
            r_olast <= fin;
        end
    end

    assign o_valid = r_ovld;
    assign o_byte  = r_obyte;
    assign o_sub   = r_osub;
    assign o_last  = r_olast;

endmodule

>>> sv/u8enc_checker.sv
// Port-level checker for the encoder top level and its bind statement.
module u8enc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_sub_is_rpl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h3F)
        else $error("substituted beat is not the replacement byte");

    a_last_not_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:6] != 2'b11)
        else $error("run ends on a lead byte");

    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7:6] == 2'b11 |-> !m_axis_tlast && !m_axis_tuser)
        else $error("lead byte flagged as run end or substitution");

endmodule

bind utf16_to_utf8_encoder_top u8enc_checker u_chk (.*);

>>> tb/sv/utf8_stream_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the UTF-8 byte stream from accepted code units and compares each beat.
module utf8_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_unit_valid,
    input  logic        i_unit_ready,
    input  logic [15:0] i_unit_data,
    input  logic        i_unit_last,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte_data,
    input  logic        i_byte_sub,
    input  logic        i_byte_last,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam logic [7:0] REPLACEMENT = 8'h3F;

    typedef struct packed {
        logic [7:0] data;
        logic       sub;
        logic       run_end;
    } t_utf8_beat;

    t_utf8_beat  expected_bytes[$];
    t_utf8_beat  unit_beats[$];
    logic        held_valid   = 1'b0;
    logic [9:0]  held_payload = '0;
    int          fails        = 0;

    function automatic logic is_high_surrogate(input logic [15:0] cu);
        return (cu >= 16'hD800) && (cu <= 16'hDBFF);
    endfunction

    function automatic logic is_low_surrogate(input logic [15:0] cu);
        return (cu >= 16'hDC00) && (cu <= 16'hDFFF);
    endfunction

    task automatic stage_beat(input logic [7:0] data, input logic sub);
        t_utf8_beat beat;
        beat.data    = data;
        beat.sub     = sub;
        beat.run_end = 1'b0;
        unit_beats.push_back(beat);
    endtask

    task automatic predict_unit(input logic [15:0] cu, input logic lst);
        logic [20:0] code_point;
        t_utf8_beat  beat;
        int          k;
        unit_beats.delete();
        if (held_valid && is_low_surrogate(cu)) begin
            code_point = 21'h10000 + {1'b0, held_payload, cu[9:0]};
            stage_beat({5'b11110, code_point[20:18]}, 1'b0);
            stage_beat({2'b10, code_point[17:12]}, 1'b0);
            stage_beat({2'b10, code_point[11:6]}, 1'b0);
            stage_beat({2'b10, code_point[5:0]}, 1'b0);
            held_valid = 1'b0;
        end else begin
            // A held high surrogate that is not completed is replaced first.
            if (held_valid) begin
                stage_beat(REPLACEMENT, 1'b1);
            end
            held_valid = 1'b0;
            if (is_high_surrogate(cu)) begin
                if (lst) begin
                    stage_beat(REPLACEMENT, 1'b1);
                end else begin
                    held_valid   = 1'b1;
                    held_payload = cu[9:0];
                end
            end else if (is_low_surrogate(cu)) begin
                stage_beat(REPLACEMENT, 1'b1);
            end else if (cu <= 16'h007F) begin
                stage_beat(cu[7:0], 1'b0);
            end else if (cu <= 16'h07FF) begin
                stage_beat({3'b110, cu[10:6]}, 1'b0);
                stage_beat({2'b10, cu[5:0]}, 1'b0);
            end else begin
                stage_beat({4'b1110, cu[15:12]}, 1'b0);
                stage_beat({2'b10, cu[11:6]}, 1'b0);
                stage_beat({2'b10, cu[5:0]}, 1'b0);
            end
        end
        for (k = 0; k < unit_beats.size(); k++) begin
            beat         = unit_beats[k];
            beat.run_end = (k == unit_beats.size() - 1);
            expected_bytes.push_back(beat);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            fails++;
            $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_utf8_beat want;
        if (!i_rst_n) begin
            expected_bytes.delete();
            held_valid   = 1'b0;
            held_payload = '0;
        end else begin
            if (i_byte_valid && i_byte_ready) begin
                if (expected_bytes.size() == 0) begin
                    fails++;
                    $error("out_byte mismatch: expected no beat, actual 0x%02h", i_byte_data);
                end else begin
                    want = expected_bytes.pop_front();
                    compare_field("out_byte", want.data, i_byte_data);
                    compare_field("substituted", {7'b0, want.sub}, {7'b0, i_byte_sub});
                    compare_field("run_end", {7'b0, want.run_end}, {7'b0, i_byte_last});
                end
            end
            if (i_unit_valid && i_unit_ready) begin
                predict_unit(i_unit_data, i_unit_last);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_bytes.size();
    end

endmodule

>>> tb/sv/tb_utf16_to_utf8_encoder_top.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-16 to UTF-8 encoder: clock, reset, stimulus, stalls and verdict.
module tb_utf16_to_utf8_encoder_top;

    localparam int UNITS_PER_PHASE = 127;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int DIRECTED_COUNT  = 22;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int outstanding;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    // Each entry is {last_unit, code_unit}.
    logic [16:0] directed_units [DIRECTED_COUNT] = '{
        17'h00000, 17'h0007F, 17'h00080, 17'h007FF, 17'h00800, 17'h0D7FF, 17'h0E000, 17'h1FFFF,
        17'h0D800, 17'h0DC00, 17'h0DBFF, 17'h1DFFF,
        17'h0DC00, 17'h1DFFF,
        17'h0D800, 17'h00041,
        17'h0DA00, 17'h0D900, 17'h0DD00,
        17'h1DBFF,
        17'h0D800, 17'h1DB00
    };

    utf16_to_utf8_encoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_unit_valid  (s_axis_tvalid),
        .i_unit_ready  (s_axis_tready),
        .i_unit_data   (s_axis_tdata),
        .i_unit_last   (s_axis_tlast),
        .i_byte_valid  (m_axis_tvalid),
        .i_byte_ready  (m_axis_tready),
        .i_byte_data   (m_axis_tdata),
        .i_byte_sub    (m_axis_tuser),
        .i_byte_last   (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic send_unit(input logic [15:0] cu, input logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cu;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] random_high_surrogate();
        return 16'($urandom_range(16'hDBFF, 16'hD800));
    endfunction

    function automatic logic [15:0] random_low_surrogate();
        return 16'($urandom_range(16'hDFFF, 16'hDC00));
    endfunction

    initial begin
        int          phase;
        int          sent;
        int          idx;
        int          kind;
        logic [15:0] cu;
        logic        lst;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 76;
        for (idx = 0; idx < DIRECTED_COUNT; idx++) begin
            send_unit(directed_units[idx][15:0], directed_units[idx][16]);
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 12;
                    rx_idle_pct = 76;
                end
                1: begin
                    tx_idle_pct = 76;
                    rx_idle_pct = 12;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < UNITS_PER_PHASE) begin
                kind = $urandom_range(9);
                lst  = ($urandom_range(7) == 0);
                case (kind)
                    0, 1: cu = 16'($urandom_range(16'h007F));
                    2: cu = 16'($urandom_range(16'h07FF, 16'h0080));
                    3, 4: begin
                        if ($urandom_range(1) == 0) begin
                            cu = 16'($urandom_range(16'hD7FF, 16'h0800));
                        end else begin
                            cu = 16'($urandom_range(16'hFFFF, 16'hE000));
                        end
                    end
                    5, 6: begin
                        send_unit(random_high_surrogate(), $urandom_range(15) == 0);
                        sent++;
                        cu = random_low_surrogate();
                    end
                    7: cu = random_low_surrogate();
                    8: cu = random_high_surrogate();
                    default: cu = 16'($urandom());
                endcase
                send_unit(cu, lst);
                sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
